@@ design/box_downscale_2x2_top_defines.svh @@
// assertion macros for the 2x2 box downscaler
`ifndef BOX_DOWNSCALE_2X2_TOP_DEFINES_SVH
`define BOX_DOWNSCALE_2X2_TOP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define BDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold
`define BDS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

@@ design/bds_pkg.sv @@
// shared types and constants of the 2x2 box downscaler
package bds_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_W         = 12;
    localparam int CHAN_W        = 8;
    localparam int SUM_W         = CHAN_W + 1;
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
        logic              row_end;
    } pix_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

endpackage

@@ design/box_downscale_2x2_top.sv @@
// result path: line store read and pair registers, then the m_ output register
// one pixel per cycle while s_ready; a line store write or read per pixel pair
// odd-row odd-column pixels raise a result; all other pixels only update state
// reset: column, row parity and held pixel cleared, width set to 640
// reset: the line store is not cleared; entries are written on each even row
`include "box_downscale_2x2_top_defines.svh"

module box_downscale_2x2_top
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  pix_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pix_out_t         m_data
);

    mem_ctrl_t        mem_ctrl;
    logic [IDX_W-1:0] mem_addr;
    pair_t            pair_sum;
    pair_t            mem_rdata;
    logic             row_end;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;

    bds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pix       (s_data),
        .mem_ctrl  (mem_ctrl),
        .mem_addr  (mem_addr),
        .pair_sum  (pair_sum),
        .row_end   (row_end)
    );

    bds_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk      (aclk),
        .mem_ctrl  (mem_ctrl),
        .mem_addr  (mem_addr),
        .mem_wdata (pair_sum),
        .mem_rdata (mem_rdata)
    );

    bds_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (mem_ctrl.rd_en),
        .pair_in    (pair_sum),
        .row_end_in (row_end),
        .rd_data    (mem_rdata),
        .take_ok    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    `BDS_ASSERT_NEVER(a_mem_one_port, mem_ctrl.wr_en && mem_ctrl.rd_en, "line store read and write in one cycle")
    `BDS_ASSERT_IMP(a_mem_on_accept, mem_ctrl.wr_en || mem_ctrl.rd_en, accept, "line store access without an accepted item")
    `BDS_ASSERT_IMP(a_stall_only_full, !s_ready, m_valid && !m_ready, "input stalled while output can drain")

endmodule

@@ design/bds_line_mem.sv @@
// line store of horizontal pair sums, with registered read data
module bds_line_mem
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic             aclk,
    input  mem_ctrl_t        mem_ctrl,
    input  logic [IDX_W-1:0] mem_addr,
    input  pair_t            mem_wdata,
    output pair_t            mem_rdata
);

    pair_t mem [LINE_DEPTH];
    pair_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctrl.wr_en) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_ctrl.rd_en) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

@@ design/bds_front.sv @@
// column tracking, pair sums and line store access of the downscaler
module bds_front
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int CW = ((WW > CFG_W) ? WW : CFG_W) + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             accept,
    input  pix_in_t          pix,
    output mem_ctrl_t        mem_ctrl,
    output logic [IDX_W-1:0] mem_addr,
    output pair_t            pair_sum,
    output logic             row_end
);

    logic [CFG_W-1:0] in_width_reg;
    pix_in_t          held_reg;
    logic [COL_W-1:0] col_reg;
    logic             odd_reg;

    logic [WW-1:0]    width_eff;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_half;
    logic             row_last;

    always_comb begin
        if (in_width_reg == '0) begin
            width_eff = WW'(1);
        end else if (CW'(in_width_reg) > CW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(in_width_reg);
        end
    end

    // clamp the column when the width shrank under it
    assign col = ((WW+1)'(col_reg) >= (WW+1)'(width_eff)) ?
                 COL_W'(width_eff - WW'(1)) : col_reg;
    assign col_half = col >> 1;
    assign mem_addr = col_half[IDX_W-1:0];

    assign row_last = ((WW+1)'(col) + (WW+1)'(1)) >= (WW+1)'(width_eff);
    assign row_end  = ((WW+2)'(col) + (WW+2)'(3)) > (WW+2)'(width_eff);

    assign pair_sum.blue  = SUM_W'(held_reg.blue_in)  + SUM_W'(pix.blue_in);
    assign pair_sum.green = SUM_W'(held_reg.green_in) + SUM_W'(pix.green_in);
    assign pair_sum.red   = SUM_W'(held_reg.red_in)   + SUM_W'(pix.red_in);

    assign mem_ctrl.wr_en = accept & col[0] & ~odd_reg;
    assign mem_ctrl.rd_en = accept & col[0] & odd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg <= WIDTH_RESET;
            held_reg     <= '0;
            col_reg      <= '0;
            odd_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                in_width_reg <= cfg_data;
            end
            if (accept) begin
                if (!col[0]) begin
                    held_reg <= pix;
                end
                if (row_last) begin
                    col_reg <= '0;
                    odd_reg <= ~odd_reg;
                end else begin
                    col_reg <= col + COL_W'(1);
                end
            end
        end
    end

endmodule

@@ design/bds_out.sv @@
// block average and output register of the downscaler
module bds_out
    import bds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     issue,
    input  pair_t    pair_in,
    input  logic     row_end_in,
    input  pair_t    rd_data,
    output logic     take_ok,
    output logic     m_valid,
    input  logic     m_ready,
    output pix_out_t m_data
);

    logic     p1_valid_reg;
    pair_t    p1_pair_reg;
    logic     p1_row_end_reg;
    logic     m_valid_reg;
    pix_out_t m_data_reg;

    logic     out_free;
    logic     advance;
    pix_out_t avg;

    logic [SUM_W:0] sum_b;
    logic [SUM_W:0] sum_g;
    logic [SUM_W:0] sum_r;

    assign out_free = ~m_valid_reg | m_ready;
    assign advance  = p1_valid_reg & out_free;
    assign take_ok  = ~p1_valid_reg | out_free;

    assign sum_b = (SUM_W+1)'(rd_data.blue)  + (SUM_W+1)'(p1_pair_reg.blue);
    assign sum_g = (SUM_W+1)'(rd_data.green) + (SUM_W+1)'(p1_pair_reg.green);
    assign sum_r = (SUM_W+1)'(rd_data.red)   + (SUM_W+1)'(p1_pair_reg.red);

    assign avg.blue_out  = sum_b[SUM_W:2];
    assign avg.green_out = sum_g[SUM_W:2];
    assign avg.red_out   = sum_r[SUM_W:2];
    assign avg.row_end   = p1_row_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (issue) begin
                p1_valid_reg <= 1'b1;
            end else if (advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_pair_reg    <= pair_in;
            p1_row_end_reg <= row_end_in;
        end
        if (advance) begin
            m_data_reg <= avg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ test/box_downscale_2x2_top_tb.sv @@
// self-checking testbench for the 2x2 box downscaler, with its own predictor
`timescale 1ns / 1ps

module box_downscale_2x2_top_tb;
    import bds_pkg::*;

    localparam int LINE_ENTRIES = MAX_WIDTH_DEF / 2;
    localparam int SETTLE = 4;

    class downscale_scoreboard;
        pair_t             line_sums [LINE_ENTRIES];
        pix_in_t           held;
        int unsigned       next_col;
        bit                on_odd_row;
        logic [CFG_W-1:0]  width;
        pix_out_t          expected_blocks [$];
        int                errors;
        int                pixels;
        int                blocks;
        int                row_ends;

        function new();
            held = '0;
            next_col = 0;
            on_odd_row = 1'b0;
            width = WIDTH_RESET;
        endfunction

        function logic [CHAN_W-1:0] quarter(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            return CHAN_W'((int'(a) + int'(b)) >> 2);
        endfunction

        function void note_pixel(pix_in_t px);
            int unsigned w;
            int unsigned c;
            pair_t       s;
            pair_t       e;
            pix_out_t    blk;
            w = (width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width;
            if (w < 1) w = 1;
            c = (next_col >= w) ? w - 1 : next_col;
            pixels++;
            if (c % 2 == 0) begin
                held = px;
            end else begin
                s.blue  = SUM_W'(held.blue_in)  + SUM_W'(px.blue_in);
                s.green = SUM_W'(held.green_in) + SUM_W'(px.green_in);
                s.red   = SUM_W'(held.red_in)   + SUM_W'(px.red_in);
                if (!on_odd_row) begin
                    line_sums[c / 2] = s;
                end else begin
                    e = line_sums[c / 2];
                    blk.blue_out  = quarter(e.blue, s.blue);
                    blk.green_out = quarter(e.green, s.green);
                    blk.red_out   = quarter(e.red, s.red);
                    blk.row_end   = (c + 3 > w);
                    expected_blocks.push_back(blk);
                end
            end
            if (c + 1 >= w) begin
                next_col = 0;
                on_odd_row = !on_odd_row;
            end else begin
                next_col = c + 1;
            end
        endfunction

        function void compare_field(string name, logic [CHAN_W-1:0] want,
                                    logic [CHAN_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_block(pix_out_t got);
            pix_out_t want;
            if (expected_blocks.size() == 0) begin
                $error("result with no block pending: %h", got);
                errors++;
                return;
            end
            want = expected_blocks.pop_front();
            blocks++;
            if (want.row_end) row_ends++;
            compare_field("blue_out", want.blue_out, got.blue_out);
            compare_field("green_out", want.green_out, got.green_out);
            compare_field("red_out", want.red_out, got.red_out);
            compare_field("row_end", CHAN_W'(want.row_end), CHAN_W'(got.row_end));
        endfunction

        function void check_leftover();
            if (expected_blocks.size() != 0) begin
                $error("%0d expected blocks never arrived", expected_blocks.size());
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    pix_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    pix_out_t         m_data;

    downscale_scoreboard sb;
    int src_gap_pct;
    int sink_stall_pct;
    int sink_hold_left;
    int widths_written;

    box_downscale_2x2_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (sink_hold_left > 0) begin
            m_ready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_block(m_data);
    end

    function automatic pix_in_t rgb(int b, int g, int r);
        pix_in_t px;
        px.blue_in  = CHAN_W'(b);
        px.green_in = CHAN_W'(g);
        px.red_in   = CHAN_W'(r);
        return px;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(9))
            0: return 0;
            1: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic pix_in_t rand_pixel();
        return rgb(rand_sample(), rand_sample(), rand_sample());
    endfunction

    task automatic send_pixel(input pix_in_t px);
        @(negedge aclk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_pixel(px);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_blocks.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        sb.width = w;
        widths_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_row_pair();
        while (sb.next_col != 0 || sb.on_odd_row) send_pixel(rand_pixel());
    endtask

    task automatic random_phase();
        int w;
        int r;
        r = $urandom_range(99);
        if (r < 70) w = $urandom_range(2, 12);
        else if (r < 92) w = $urandom_range(13, 64);
        else w = $urandom_range(65, 128);
        write_width(CFG_W'(w));
        repeat ($urandom_range(1, 4 * w)) send_pixel(rand_pixel());
        // width change part way through an even row
        if ($urandom_range(3) == 0) begin
            while (sb.on_odd_row || sb.next_col == 0) send_pixel(rand_pixel());
            write_width(CFG_W'($urandom_range(2, 12)));
        end
        finish_row_pair();
    endtask

    initial begin
        int start;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        src_gap_pct    = 29;
        sink_stall_pct = 51;
        sink_hold_left = 0;
        widths_written = 0;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset width of 640, cut short mid-row
        repeat (3) send_pixel(rand_pixel());
        write_width(CFG_W'(2));
        finish_row_pair();

        write_width(CFG_W'(2));
        repeat (4) send_pixel(rgb(255, 255, 255));
        repeat (4) send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(3, 0, 255));
        send_pixel(rgb(3, 1, 255));
        send_pixel(rgb(0, 2, 0));
        send_pixel(rgb(1, 0, 254));

        // odd width drops the last column
        write_width(CFG_W'(3));
        send_pixel(rgb(10, 20, 30));
        send_pixel(rgb(40, 50, 60));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(1, 2, 3));
        send_pixel(rgb(4, 5, 6));
        send_pixel(rgb(0, 0, 0));

        write_width(CFG_W'(1));
        repeat (2) send_pixel(rand_pixel());
        write_width(CFG_W'(0));
        repeat (2) send_pixel(rand_pixel());

        // shrink below the current column mid-row
        write_width(CFG_W'(6));
        repeat (3) send_pixel(rand_pixel());
        write_width(CFG_W'(2));
        finish_row_pair();

        // saturates to the largest line
        write_width('1);
        repeat (5) send_pixel(rand_pixel());
        write_width(CFG_W'(2));
        finish_row_pair();

        for (int mode = 0; mode < 3; mode++) begin
            src_gap_pct    = (mode == 0) ? 29 : (mode == 1) ? 51 : 0;
            sink_stall_pct = (mode == 0) ? 51 : (mode == 1) ? 29 : 0;
            start = sb.pixels;
            if (mode == 0) begin
                write_width(CFG_W'(4));
                sink_hold_left = 300;
                repeat (160) send_pixel(rand_pixel());
                drain_results();
                finish_row_pair();
            end
            while (sb.pixels - start < 180) random_phase();
        end

        drain_results();
        repeat (20) @(posedge aclk);
        sb.check_leftover();
        $display("run covered %0d pixels and %0d blocks, %0d of them ending a row",
                 sb.pixels, sb.blocks, sb.row_ends);
        $display("%0d width writes from 0 to 4095, incl. a mid-row change, hold-off and drain",
                 widths_written);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
